// File: rtl/core/sorted_interval_merger_core_assert.svh
// Assertion macros for the sorted interval merger checker.
// Expect clk and rst_n in the scope of each use.
`ifndef SORTED_INTERVAL_MERGER_CORE_ASSERT_SVH
`define SORTED_INTERVAL_MERGER_CORE_ASSERT_SVH

// Check while out of reset.
`define SIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define SIM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sim_pkg.sv
// Package for the sorted interval merger: field widths, stream packing, types.
// No dependencies; imported by every module of the block.
`default_nettype none

package sim_pkg;

  localparam int CHROM_ID_BITS = 16;
  localparam int COORD_BITS    = 32;
  localparam int PAD_BITS      = 31;
  localparam int COUNT_BITS    = 32;

  localparam int IN_RAW_BITS   = CHROM_ID_BITS + 2 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int NUM_LSB       = CHROM_ID_BITS + 2 * COORD_BITS;
  localparam int OUT_RAW_BITS  = NUM_LSB + COUNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);
  localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

  typedef logic [CHROM_ID_BITS-1:0] chrom_t;
  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [COUNT_BITS-1:0]    count_t;

  typedef struct packed {
    count_t part_number;
    coord_t part_end;
    coord_t part_start;
    chrom_t part_chrom;
    logic   last_result;
  } part_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_interval_merger_core.sv
// Top level of the sorted interval merger: stream ports, merge stage, result queue.
// Depends on sim_pkg, sim_merge and sim_outq.
//
//   channel | direction | transaction
//   in_     | slave     | one interval record, tlast marks end of stream
//   out_    | master    | one merged partition, tlast marks last of stream
//   cfg_    | write     | merge padding, taken at any edge out of reset with cfg_wr_en high
//
// One record per cycle while in_tready is high; its partitions wait in the queue for out_.
// A record yields zero, one or two partitions; the queue holds four.
// in_tready drops while fewer than two queue entries are free.
// Reset is synchronous on rst_n low and empties the queue and the open partition.
`default_nettype none

module sorted_interval_merger_core
  import sim_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // record_chrom, record_start, record_end
  input  logic                     in_tlast,   // end_of_stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // part_chrom, part_start, part_end, part_number
  output logic                     out_tlast,  // last_result
  input  logic                     cfg_wr_en,
  input  logic [PAD_BITS-1:0]      cfg_wr_data // merge_padding
);

  logic   in_acc;
  logic   pop;
  logic   space;
  push_t  push;
  part_t  res_a;
  part_t  res_b;
  part_t  head;
  chrom_t rec_chrom;
  coord_t rec_start;
  coord_t rec_end;

  assign in_tready = space;
  assign in_acc    = in_tvalid && space;
  assign pop       = out_tvalid && out_tready;

  assign rec_chrom = in_tdata[CHROM_ID_BITS-1:0];
  assign rec_start = in_tdata[CHROM_ID_BITS +: COORD_BITS];
  assign rec_end   = in_tdata[CHROM_ID_BITS + COORD_BITS +: COORD_BITS];

  sim_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rec_acc     (in_acc),
    .rec_chrom   (rec_chrom),
    .rec_start   (rec_start),
    .rec_end     (rec_end),
    .rec_eos     (in_tlast),
    .push        (push),
    .res_a       (res_a),
    .res_b       (res_b)
  );

  sim_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res_a      (res_a),
    .res_b      (res_b),
    .pop        (pop),
    .space      (space),
    .head_valid (out_tvalid),
    .head       (head)
  );

  assign out_tdata = OUT_DATA_BITS'({head.part_number, head.part_end,
                                     head.part_start, head.part_chrom});
  assign out_tlast = head.last_result;

endmodule

`default_nettype wire

// File: rtl/core/sim_merge.sv
// Merge stage: padding register, open partition state and the per-record decision.
// Depends on sim_pkg; emits up to two partitions per accepted record.
`default_nettype none

module sim_merge
  import sim_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [PAD_BITS-1:0] cfg_wr_data,
  input  logic                rec_acc,
  input  chrom_t              rec_chrom,
  input  coord_t              rec_start,
  input  coord_t              rec_end,
  input  logic                rec_eos,
  output push_t               push,
  output part_t               res_a,
  output part_t               res_b
);

  logic [PAD_BITS-1:0] pad_r;
  logic                open_valid_r;
  chrom_t              open_chrom_r;
  coord_t              open_start_r;
  coord_t              open_end_r;
  count_t              count_r;

  logic                open_valid_nxt;
  chrom_t              open_chrom_nxt;
  coord_t              open_start_nxt;
  coord_t              open_end_nxt;
  count_t              count_nxt;

  coord_t pad_ext;
  coord_t pstart;
  logic   overlap;
  logic   closing;
  coord_t mstart;
  coord_t mend;

  assign pad_ext = COORD_BITS'(pad_r);
  assign pstart  = (rec_start >= pad_ext) ? (rec_start - pad_ext) : '0;
  assign overlap = open_valid_r && (rec_chrom == open_chrom_r) &&
                   (pstart < open_end_r) && (rec_end > open_start_r);
  assign closing = open_valid_r && !overlap;

  assign mstart = (overlap && (open_start_r < pstart)) ? open_start_r : pstart;
  assign mend   = (overlap && (open_end_r > rec_end)) ? open_end_r : rec_end;

  always_comb begin
    if (closing) begin
      res_a.part_chrom  = open_chrom_r;
      res_a.part_start  = open_start_r;
      res_a.part_end    = open_end_r;
      res_a.part_number = count_r;
      res_a.last_result = 1'b0;
    end else begin
      res_a.part_chrom  = rec_chrom;
      res_a.part_start  = mstart;
      res_a.part_end    = mend;
      res_a.part_number = count_r;
      res_a.last_result = 1'b1;
    end
    res_b.part_chrom  = rec_chrom;
    res_b.part_start  = mstart;
    res_b.part_end    = mend;
    res_b.part_number = count_r + COUNT_BITS'(1);
    res_b.last_result = 1'b1;
  end

  assign push.push_a = rec_acc && (closing || rec_eos);
  assign push.push_b = rec_acc && closing && rec_eos;

  always_comb begin
    open_valid_nxt = open_valid_r;
    open_chrom_nxt = open_chrom_r;
    open_start_nxt = open_start_r;
    open_end_nxt   = open_end_r;
    count_nxt      = count_r;
    if (rec_acc) begin
      if (rec_eos) begin
        open_valid_nxt = 1'b0;
        open_chrom_nxt = '0;
        open_start_nxt = '0;
        open_end_nxt   = '0;
        count_nxt      = '0;
      end else begin
        open_valid_nxt = 1'b1;
        open_chrom_nxt = rec_chrom;
        open_start_nxt = mstart;
        open_end_nxt   = mend;
        count_nxt      = count_r + COUNT_BITS'(closing);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r        <= '0;
      open_valid_r <= 1'b0;
      open_chrom_r <= '0;
      open_start_r <= '0;
      open_end_r   <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        pad_r <= cfg_wr_data;
      end
      open_valid_r <= open_valid_nxt;
      open_chrom_r <= open_chrom_nxt;
      open_start_r <= open_start_nxt;
      open_end_r   <= open_end_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sim_outq.sv
// Result queue: small register array taking up to two partitions per cycle.
// Depends on sim_pkg; head entry drives the output stream.
`default_nettype none

module sim_outq
  import sim_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  part_t res_a,
  input  part_t res_b,
  input  logic  pop,
  output logic  space,
  output logic  head_valid,
  output part_t head
);

  part_t                q_mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;

  logic [QPTR_BITS-1:0] wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_nxt;
  logic [QPTR_BITS-1:0] wr_ptr_b;

  assign wr_ptr_b   = wr_ptr_r + QPTR_BITS'(1);
  assign space      = (cnt_r <= QCNT_BITS'(QDEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(push.push_a) + QPTR_BITS'(push.push_b);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(pop);
  assign cnt_nxt    = cnt_r + QCNT_BITS'(push.push_a) + QCNT_BITS'(push.push_b)
                      - QCNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      q_mem_r[wr_ptr_r] <= res_a;
    end
    if (push.push_b) begin
      q_mem_r[wr_ptr_b] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sim_port_check.sv
// Port checker for the sorted interval merger output stream, bound to the top level.
// Depends on sim_pkg and sorted_interval_merger_core_assert.svh.
`default_nettype none
`include "sorted_interval_merger_core_assert.svh"

module sim_port_check
  import sim_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic                     out_tlast
);

  logic   out_acc;
  count_t out_num;

  assign out_acc = out_tvalid && out_tready;
  assign out_num = out_tdata[NUM_LSB +: COUNT_BITS];

  `SIM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output transaction changed while stalled")
  `SIM_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "output valid right after reset")
  `SIM_ASSERT(a_num_restart, out_acc && out_tlast |=> !out_tvalid || (out_num == '0), "partition number did not restart after last")
  `SIM_ASSERT(a_num_step, out_acc && !out_tlast |=> !out_tvalid || (out_num == $past(out_num) + COUNT_BITS'(1)), "partition number did not advance by one")

endmodule

bind sorted_interval_merger_core sim_port_check u_port_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// File: tb/tb_sorted_interval_merger_core.sv
// Testbench for sorted_interval_merger_core: drives interval record streams under random
// stalls and checks each merged partition against a scoreboard's own prediction.
// Depends on sim_pkg and the RTL of sorted_interval_merger_core.

module tb_sorted_interval_merger_core;
  import sim_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int RUN_LIMIT     = 2000000;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;

  class partition_tracker;
    logic [PAD_BITS-1:0] padding;
    logic                open_valid;
    chrom_t              open_chrom;
    coord_t              open_lo;
    coord_t              open_hi;
    count_t              part_count;
    part_t               expected_parts[$];
    int                  mismatches;

    function new();
      padding    = '0;
      open_valid = 1'b0;
      open_chrom = '0;
      open_lo    = '0;
      open_hi    = '0;
      part_count = '0;
      mismatches = 0;
    endfunction

    function part_t close_open(logic last);
      part_t p;
      p.part_chrom  = open_chrom;
      p.part_start  = open_lo;
      p.part_end    = open_hi;
      p.part_number = part_count;
      p.last_result = last;
      part_count    = part_count + 1'b1;
      return p;
    endfunction

    function void note_record(chrom_t chrom, coord_t start, coord_t stop, logic eos);
      coord_t lo;
      lo = (start >= {1'b0, padding}) ? start - {1'b0, padding} : '0;
      if (open_valid && chrom == open_chrom && lo < open_hi && stop > open_lo) begin
        if (lo < open_lo) open_lo = lo;
        if (stop > open_hi) open_hi = stop;
      end else begin
        if (open_valid) expected_parts.push_back(close_open(1'b0));
        open_valid = 1'b1;
        open_chrom = chrom;
        open_lo    = lo;
        open_hi    = stop;
      end
      if (eos) begin
        expected_parts.push_back(close_open(1'b1));
        open_valid = 1'b0;
        open_chrom = '0;
        open_lo    = '0;
        open_hi    = '0;
        part_count = '0;
      end
    endfunction

    function int pending();
      return expected_parts.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_partition(part_t got);
      part_t want;
      if (expected_parts.size() == 0) begin
        report($sformatf("unexpected partition chrom %0h start %0h end %0h number %0d",
                         got.part_chrom, got.part_start, got.part_end, got.part_number));
      end else begin
        want = expected_parts.pop_front();
        if (got.part_chrom !== want.part_chrom)
          report($sformatf("part_chrom got %0h want %0h", got.part_chrom, want.part_chrom));
        if (got.part_start !== want.part_start)
          report($sformatf("part_start got %0h want %0h", got.part_start, want.part_start));
        if (got.part_end !== want.part_end)
          report($sformatf("part_end got %0h want %0h", got.part_end, want.part_end));
        if (got.part_number !== want.part_number)
          report($sformatf("part_number got %0d want %0d", got.part_number, want.part_number));
        if (got.last_result !== want.last_result)
          report($sformatf("last_result got %0b want %0b", got.last_result, want.last_result));
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;   // record_chrom, record_start, record_end
  logic                     in_tlast;   // end_of_stream
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;  // part_chrom, part_start, part_end, part_number
  logic                     out_tlast;  // last_result
  logic                     cfg_wr_en;
  logic [PAD_BITS-1:0]      cfg_wr_data;

  rx_mode_t         rx_mode    = RX_ALWAYS;
  bit               hold_req   = 1'b0;
  int               gap_max    = 0;
  int               burst_left = 0;
  part_t            seen_part;
  partition_tracker tracker    = new();

  sorted_interval_merger_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_part.part_chrom  = out_tdata[CHROM_ID_BITS-1:0];
      seen_part.part_start  = out_tdata[CHROM_ID_BITS +: COORD_BITS];
      seen_part.part_end    = out_tdata[CHROM_ID_BITS+COORD_BITS +: COORD_BITS];
      seen_part.part_number = out_tdata[NUM_LSB +: COUNT_BITS];
      seen_part.last_result = out_tlast;
      tracker.check_partition(seen_part);
    end
  end

  initial begin : receiver
    int tick;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      tick++;
      case (rx_mode)
        RX_ALWAYS:  out_tready <= 1'b1;
        RX_MOSTLY:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_tready <= (tick % 7 > 2) || (tick % 13 == 0);
        default:    out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("FAIL");
    $finish;
  end

  task automatic send_record(chrom_t chrom, coord_t start, coord_t stop, logic eos);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_BITS'({stop, start, chrom});
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_record(chrom, start, stop, eos);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_padding(logic [PAD_BITS-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.padding = value;
  endtask

  task automatic offer_record(chrom_t chrom, coord_t start, coord_t stop, logic eos);
    if (burst_left == 0) begin
      if (gap_max > 0) idle_cycles($urandom_range(0, gap_max));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_record(chrom, start, stop, eos);
  endtask

  task automatic run_phase(logic [PAD_BITS-1:0] pad, rx_mode_t mode, int gaps, int n_items,
                           bit pressure);
    int     sent;
    int     n;
    int     span;
    bit     closes;
    chrom_t chrom;
    coord_t start;
    coord_t stop;
    write_padding(pad);
    rx_mode    = mode;
    gap_max    = gaps;
    burst_left = 0;
    span       = (pad < 200) ? 2 * pad + 40 : 400;
    sent       = 0;
    if (pressure) begin
      hold_req = 1'b1;
      gap_max  = 0;
    end
    while (sent < n_items) begin
      if (pressure && sent >= 80) begin
        // hold the sender until the backlog is gone
        drain_results();
        pressure = 1'b0;
        gap_max  = gaps;
      end
      n      = $urandom_range(1, 12);
      closes = ($urandom_range(0, 7) != 0);
      chrom  = ($urandom_range(0, 3) != 0) ? chrom_t'($urandom_range(0, 40)) : chrom_t'($urandom);
      start  = ($urandom_range(0, 3) != 0) ? coord_t'($urandom_range(0, 5000)) : coord_t'($urandom);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          offer_record(chrom_t'($urandom), $urandom, $urandom, $urandom_range(0, 3) == 0);
        end else begin
          if ($urandom_range(0, 7) == 0) begin
            chrom = chrom + chrom_t'($urandom_range(1, 3));
            start = $urandom_range(0, 3000);
          end else if ($urandom_range(0, 3) == 0) begin
            start = start + $urandom_range(0, span);
          end else begin
            start = start + $urandom_range(0, 40);
          end
          case ($urandom_range(0, 15))
            0:       stop = start;
            1:       stop = start - $urandom_range(1, 20);
            default: stop = start + $urandom_range(1, 120);
          endcase
          offer_record(chrom, start, stop, closes && i == n - 1);
        end
      end
      sent += n;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rx_mode = RX_ALWAYS;
    write_padding(31'd10);
    send_record(16'd5, 32'd100, 32'd200, 1'b0);
    send_record(16'd5, 32'd205, 32'd300, 1'b0);
    send_record(16'd5, 32'd310, 32'd400, 1'b0);
    send_record(16'd5, 32'd10, 32'd20, 1'b0);
    send_record(16'd5, 32'd3, 32'd15, 1'b0);
    send_record(16'd5, 32'd50, 32'd50, 1'b0);
    send_record(16'd5, 32'd60, 32'd30, 1'b0);
    send_record(16'd6, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_record(16'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_record(16'hFFFF, 32'd0, 32'd1, 1'b1);
    send_record(16'd0, 32'd1000, 32'd2000, 1'b0);
    send_record(16'd0, 32'd5000, 32'd6000, 1'b1);
    write_padding(31'h7FFF_FFFF);
    send_record(16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_record(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_record(16'd1, 32'h7FFF_FFFE, 32'd5, 1'b1);
    write_padding(31'd0);
    send_record(16'd2, 32'd0, 32'd0, 1'b0);
    send_record(16'd2, 32'd0, 32'd0, 1'b1);

    run_phase(31'd0, RX_ALWAYS, 0, 250, 1'b0);
    run_phase(31'd1, RX_MOSTLY, 4, 250, 1'b0);
    run_phase(31'd30, RX_PATTERN, 6, 300, 1'b1);
    run_phase(31'h7FFF_FFFF, RX_SPARSE, 2, 250, 1'b0);
    run_phase(PAD_BITS'($urandom_range(0, 100)), RX_MOSTLY, 8, 300, 1'b0);
    run_phase(PAD_BITS'($urandom), RX_PATTERN, 3, 300, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
